[sv/cta_pkg.sv]
// Shared types and constants for the charset translator with internal code allocation.
// No dependencies; imported by cta_ram users and the top level.
`default_nettype none

package cta_pkg;

  // Internal code space size and external byte width
  localparam int CODE_SLOTS = 256;
  localparam int BYTE_W = 8;

  // Parameter defaults for the top level
  localparam int NUM_CHARSETS_DEF = 8;
  localparam int UNICODE_BITS_DEF = 16;

  // Request kinds
  localparam logic [1:0] REQ_LOAD   = 2'd0;
  localparam logic [1:0] REQ_ENCODE = 2'd1;
  localparam logic [1:0] REQ_DECODE = 2'd2;

  // Result status codes
  localparam logic [2:0] ST_OK          = 3'd0;
  localparam logic [2:0] ST_NO_UNICODE  = 3'd1;
  localparam logic [2:0] ST_TABLE_FULL  = 3'd2;
  localparam logic [2:0] ST_DEFAULT_UND = 3'd3;
  localparam logic [2:0] ST_UNHANDLED   = 3'd4;
  localparam logic [2:0] ST_BAD_INT     = 3'd5;

  // Configuration register indexes
  localparam logic CFG_RELAX   = 1'b0;
  localparam logic CFG_DEFAULT = 1'b1;

  // Sequencer states
  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_LOOK,
    S_SCAN,
    S_RELAX_RD,
    S_RELAX,
    S_FIN
  } cta_state_t;

endpackage

`default_nettype wire

[sv/cta_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`default_nettype none

module cta_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port, then registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[sv/charset_translate_alloc_core.sv]
// Top level of the charset translator: request sequencer around four state RAMs.
// Depends on cta_pkg and cta_ram.
`default_nettype none

// Usage:
//   Requests enter on the in_valid/in_ready channel (load map entry, encode,
//   decode); each request yields exactly one result transaction on the
//   out_valid/out_ready channel (code_out, status, allocated).
//   Configuration (relax mode index 0, substitute byte index 1) is written via
//   cfg_we/cfg_index/cfg_data with no handshake; the user must write it only
//   while the block is idle, which the block does not enforce. One request is
//   processed at a time. A lookup hit, decode or load that links through the
//   hint slot passes accept + RAM read (S_IDLE), evaluate (S_LOOK) and commit
//   (S_FIN); out_valid is registered at the commit. Relax substitution adds
//   S_RELAX_RD and S_RELAX for the second forward table read. A search of the
//   internal code table (load without hint match, encode allocation) streams
//   through the internal unicode RAM one slot per cycle.
//   The result sits in an output register; the next request is accepted
//   while it waits, but the commit of that request holds until the
//   receiver takes the previous result.
//   After reset a clearing pass writes every map RAM entry, one per cycle
//   (NUM_CHARSETS*256 entries rounded up to a power of two, 2048 by default),
//   installing the ASCII identity for charset 0; in_ready stays low during it.

module charset_translate_alloc_core #(
  parameter int NUM_CHARSETS = cta_pkg::NUM_CHARSETS_DEF,
  parameter int UNICODE_BITS = cta_pkg::UNICODE_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output      logic        in_ready,
  input  wire logic [1:0]  req_type,
  input  wire logic [2:0]  charset,
  input  wire logic [7:0]  byte_in,
  input  wire logic [15:0] unicode_in,
  input  wire logic        allow_alloc,
  output      logic        out_valid,
  input  wire logic        out_ready,
  output      logic [7:0]  code_out,
  output      logic [2:0]  status,
  output      logic        allocated,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [7:0]  cfg_data
);
  import cta_pkg::*;

  localparam int CS_W = (NUM_CHARSETS > 1) ? $clog2(NUM_CHARSETS) : 1;
  localparam int MAP_AW = CS_W + BYTE_W;
  localparam int MAP_DEPTH = 1 << MAP_AW;
  localparam int UW = UNICODE_BITS;

  cta_state_t state, state_next;

  // Config registers
  logic       relax_mode;
  logic [7:0] subst_char;

  // Request registers
  logic [1:0]      req;
  logic [CS_W-1:0] cs;
  logic [7:0]      b;
  logic [UW-1:0]   uni;
  logic            alloc;
  logic            bad;

  // Evaluation registers
  logic [UW-1:0] target;
  logic [UW-1:0] iu_b;
  logic          scan_load;
  logic [7:0]    scan_idx;
  logic          scan_done;
  logic [7:0]    rd_idx;
  logic          rd_vld;
  logic [7:0]    free_idx;
  logic          free_vld;
  logic [MAP_AW-1:0] clr_cnt;

  // Pending result and commit controls
  logic [7:0] r_code;
  logic [2:0] r_status;
  logic       r_alloc;
  logic       wr_cu;
  logic       wr_map;
  logic       wr_int;

  // RAM ports
  logic [UW-1:0]     iu_rdata, cu_rdata, iu_wdata, cu_wdata;
  logic [7:0]        fw_rdata, rv_rdata, fw_wdata, rv_wdata;
  logic [7:0]        iu_raddr, iu_waddr;
  logic [MAP_AW-1:0] map_raddr, fw_raddr, rv_waddr, map_waddr;
  logic              iu_we, cu_we, fw_we, rv_we;

  logic [5:0]        cs_ext;
  logic [CS_W-1:0]   cs_in;
  logic [20:0]       uni_wide;
  logic              accept;
  logic              out_free;
  logic              fin_go;
  logic              init_low;
  logic [UW-1:0]     b_uni;
  logic [UW-1:0]     u_sel;
  logic              last_rd;
  logic              scan_hit;

  assign cs_ext   = {3'b000, charset};
  assign cs_in    = cs_ext[CS_W-1:0];
  assign uni_wide = {5'b00000, unicode_in};
  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign fin_go   = (state == S_FIN) && out_free;
  assign init_low = (clr_cnt[MAP_AW-1:7] == '0);
  assign b_uni    = UW'(b);
  assign last_rd  = rd_vld && (rd_idx == 8'd0);
  assign scan_hit = rd_vld && (iu_rdata == target);

  // Unicode chosen for an encode allocation
  always_comb begin
    u_sel = cu_rdata;
    if (cu_rdata == '0) begin
      if (((b < 8'd32) && (iu_rdata == '0)) || (iu_rdata == b_uni)) begin
        u_sel = b_uni;
      end
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: begin
        if (clr_cnt == '1) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (accept) state_next = S_LOOK;
      end
      S_LOOK: begin
        state_next = S_FIN;
        if (!bad) begin
          if (req == REQ_LOAD) begin
            if ((uni != '0) && (iu_rdata != uni)) state_next = S_SCAN;
          end else if (req == REQ_ENCODE) begin
            if ((fw_rdata == 8'd0) && (b != 8'd0)) begin
              if (alloc) begin
                if ((u_sel != '0) && (iu_rdata != u_sel)) state_next = S_SCAN;
              end else if (relax_mode) begin
                state_next = S_RELAX_RD;
              end
            end
          end
        end
      end
      S_SCAN: begin
        if (scan_hit || last_rd) state_next = S_FIN;
      end
      S_RELAX_RD: state_next = S_RELAX;
      S_RELAX:    state_next = S_FIN;
      S_FIN: begin
        if (out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // RAM addressing and writes
  always_comb begin
    map_raddr = {cs, b};
    fw_raddr  = {cs, b};
    iu_raddr  = b;
    if (state == S_IDLE) begin
      map_raddr = {cs_in, byte_in};
      fw_raddr  = {cs_in, byte_in};
      iu_raddr  = byte_in;
    end else if (state == S_RELAX_RD) begin
      fw_raddr = {cs, subst_char};
    end else if (state == S_SCAN) begin
      iu_raddr = scan_idx;
    end

    map_waddr = {cs, b};
    rv_waddr  = {cs, r_code};
    iu_waddr  = r_code;
    cu_wdata  = uni;
    fw_wdata  = r_code;
    rv_wdata  = b;
    iu_wdata  = target;
    cu_we     = fin_go && wr_cu;
    fw_we     = fin_go && wr_map;
    rv_we     = fin_go && wr_map;
    iu_we     = fin_go && wr_int;
    if (state == S_CLEAR) begin
      map_waddr = clr_cnt;
      rv_waddr  = clr_cnt;
      iu_waddr  = clr_cnt[7:0];
      cu_wdata  = init_low ? UW'(clr_cnt[7:0]) : '0;
      fw_wdata  = init_low ? clr_cnt[7:0] : 8'd0;
      rv_wdata  = init_low ? clr_cnt[7:0] : 8'd0;
      iu_wdata  = '0;
      cu_we     = 1'b1;
      fw_we     = 1'b1;
      rv_we     = 1'b1;
      iu_we     = 1'b1;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLEAR;
      clr_cnt      <= '0;
      relax_mode   <= 1'b0;
      subst_char   <= 8'd0;
      out_valid    <= 1'b0;
      rd_vld       <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_CLEAR) clr_cnt <= clr_cnt + 1'b1;
      if (cfg_we) begin
        case (cfg_index)
          CFG_RELAX:   relax_mode <= cfg_data[0];
          CFG_DEFAULT: subst_char <= cfg_data;
          default: ;
        endcase
      end
      if (fin_go) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      rd_vld <= (state == S_SCAN) && !scan_done && !scan_hit;
    end
  end

  // Request capture, evaluation and result
  always_ff @(posedge clk) begin
    if (accept) begin
      req   <= req_type;
      cs    <= cs_in;
      b     <= byte_in;
      uni   <= uni_wide[UW-1:0];
      alloc <= allow_alloc;
      bad   <= (req_type == 2'd3) || ({4'b0000, charset} >= 7'(NUM_CHARSETS));
    end

    if (fin_go) begin
      code_out  <= r_code;
      status    <= r_status;
      allocated <= r_alloc;
    end

    // Scan: issue one slot per cycle from 255 down, evaluate it in the next cycle
    if (state == S_SCAN) begin
      rd_idx <= scan_idx;
      if (scan_idx == 8'd0) scan_done <= 1'b1;
      scan_idx <= scan_idx - 8'd1;
      if (rd_vld) begin
        if (scan_hit) begin
          r_code   <= rd_idx;
          r_status <= ST_OK;
          r_alloc  <= 1'b0;
          wr_map   <= 1'b1;
          wr_int   <= !scan_load;
        end else begin
          if ((iu_rdata == '0) && (rd_idx != 8'd0) && !free_vld) begin
            free_idx <= rd_idx;
            free_vld <= 1'b1;
          end
          if (last_rd) begin
            if (scan_load) begin
              r_code <= 8'd0;
              wr_map <= 1'b0;
            end else if (iu_b == '0) begin
              r_code  <= b;
              r_alloc <= 1'b1;
              wr_map  <= 1'b1;
              wr_int  <= 1'b1;
            end else if (free_vld) begin
              r_code  <= free_idx;
              r_alloc <= 1'b1;
              wr_map  <= 1'b1;
              wr_int  <= 1'b1;
            end else begin
              r_code   <= 8'd0;
              r_status <= ST_TABLE_FULL;
            end
          end
        end
      end
    end

    // Relax: substitute character lookup
    if (state == S_RELAX) begin
      r_code   <= fw_rdata;
      r_status <= (fw_rdata == 8'd0) ? ST_DEFAULT_UND : ST_OK;
    end

    // First look at RAM data
    if (state == S_LOOK) begin
      iu_b      <= iu_rdata;
      scan_idx  <= 8'd255;
      scan_done <= 1'b0;
      free_vld  <= 1'b0;
      free_idx  <= 8'd0;
      r_alloc   <= 1'b0;
      r_status  <= ST_OK;
      r_code    <= 8'd0;
      wr_cu     <= 1'b0;
      wr_map    <= 1'b0;
      wr_int    <= 1'b0;
      scan_load <= (req == REQ_LOAD);
      target    <= (req == REQ_LOAD) ? uni : u_sel;
      if (bad) begin
        r_status <= ST_UNHANDLED;
      end else if (req == REQ_LOAD) begin
        wr_cu <= 1'b1;
        if ((uni != '0) && (iu_rdata == uni)) begin
          r_code <= b;
          wr_map <= 1'b1;
        end
      end else if (req == REQ_DECODE) begin
        r_code   <= rv_rdata;
        if ((rv_rdata == 8'd0) && (b != 8'd0)) r_status <= ST_BAD_INT;
      end else begin
        if ((fw_rdata != 8'd0) || (b == 8'd0)) begin
          r_code <= fw_rdata;
        end else if (alloc) begin
          if (u_sel == '0) begin
            r_status <= ST_NO_UNICODE;
          end else if (iu_rdata == u_sel) begin
            r_code <= b;
            wr_map <= 1'b1;
            wr_int <= 1'b1;
          end
        end else if (!relax_mode) begin
          r_status <= ST_UNHANDLED;
        end
      end
    end
  end

  cta_ram #(.WIDTH(UW), .DEPTH(CODE_SLOTS)) u_internal_unicode (
    .clk(clk), .we(iu_we), .waddr(iu_waddr), .wdata(iu_wdata),
    .raddr(iu_raddr), .rdata(iu_rdata)
  );

  cta_ram #(.WIDTH(UW), .DEPTH(MAP_DEPTH)) u_charset_unicode (
    .clk(clk), .we(cu_we), .waddr(map_waddr), .wdata(cu_wdata),
    .raddr(map_raddr), .rdata(cu_rdata)
  );

  cta_ram #(.WIDTH(BYTE_W), .DEPTH(MAP_DEPTH)) u_forward_map (
    .clk(clk), .we(fw_we), .waddr(map_waddr), .wdata(fw_wdata),
    .raddr(fw_raddr), .rdata(fw_rdata)
  );

  cta_ram #(.WIDTH(BYTE_W), .DEPTH(MAP_DEPTH)) u_reverse_map (
    .clk(clk), .we(rv_we), .waddr(rv_waddr), .wdata(rv_wdata),
    .raddr(map_raddr), .rdata(rv_rdata)
  );

endmodule

`default_nettype wire

[tb/tb_charset_translate_alloc_core.sv]
// Self-checking testbench for the charset translator with internal code allocation.
// Depends on cta_pkg and charset_translate_alloc_core; predicts every result in-line.
`timescale 1ns / 1ps

module tb_charset_translate_alloc_core;
  import cta_pkg::*;

  typedef struct packed {
    logic [1:0]  kind;
    logic [2:0]  cs;
    logic [7:0]  byt;
    logic [15:0] uni;
    logic        alloc;
  } xlat_req_t;

  typedef struct packed {
    logic [7:0] code;
    logic [2:0] st;
    logic       alloc;
  } xlat_res_t;

  localparam int CYCLE_LIMIT = 3000000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  req_type = '0;
  logic [2:0]  charset = '0;
  logic [7:0]  byte_in = '0;
  logic [15:0] unicode_in = '0;
  logic        allow_alloc = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  code_out;
  logic [2:0]  status;
  logic        allocated;
  logic        cfg_we = 1'b0;
  logic        cfg_index = 1'b0;
  logic [7:0]  cfg_data = '0;

  charset_translate_alloc_core dut (.*);

  always #1 clk = ~clk;

  // Shadow state of the translator
  logic [15:0] slot_uni [256];
  logic [15:0] byte_uni [2048];
  logic [7:0]  fwd_code [2048];
  logic [7:0]  rev_byte [2048];
  logic        relax_on;
  logic [7:0]  subst_byte;

  xlat_req_t pending_reqs [$];
  xlat_res_t expected_results [$];
  int  send_idle_pct, recv_stall_pct;
  int  errors, cycles, n_sent, n_recv, n_alloc, n_err_status;
  bit  hold_send;

  function automatic int find_slot(logic [15:0] u, int hint);
    if (u == 0) return 0;
    if (slot_uni[hint] == u) return hint;
    for (int i = 255; i >= 0; i--)
      if (slot_uni[i] == u) return i;
    return 0;
  endfunction

  // Compute the result of one request and update the shadow state
  function automatic xlat_res_t translate(xlat_req_t r);
    xlat_res_t res;
    int base, e, slot, b;
    logic [15:0] u;
    bit fresh;
    res = '0;
    b = r.byt;
    if (r.kind == 2'd3) begin
      res.st = ST_UNHANDLED;
      return res;
    end
    base = r.cs * 256;
    if (r.kind == REQ_LOAD) begin
      e = find_slot(r.uni, b);
      byte_uni[base + b] = r.uni;
      if (e != 0) begin
        fwd_code[base + b] = 8'(e);
        rev_byte[base + e] = 8'(b);
      end
      res.code = 8'(e);
      return res;
    end
    if (r.kind == REQ_DECODE) begin
      if (rev_byte[base + b] == 0 && b != 0) res.st = ST_BAD_INT;
      else res.code = rev_byte[base + b];
      return res;
    end
    if (fwd_code[base + b] != 0 || b == 0) begin
      res.code = fwd_code[base + b];
      return res;
    end
    if (r.alloc) begin
      fresh = 0;
      u = byte_uni[base + b];
      if (u == 0 && ((b < 32 && slot_uni[b] == 0) || slot_uni[b] == b)) u = 16'(b);
      if (u == 0) begin
        res.st = ST_NO_UNICODE;
        return res;
      end
      slot = find_slot(u, b);
      if (slot == 0) begin
        if (slot_uni[b] == 0) slot = b;
        else
          for (int i = 255; i > 0; i--)
            if (slot_uni[i] == 0) begin
              slot = i;
              break;
            end
        if (slot == 0) begin
          res.st = ST_TABLE_FULL;
          return res;
        end
        fresh = 1;
      end
      slot_uni[slot] = u;
      fwd_code[base + b] = 8'(slot);
      rev_byte[base + slot] = 8'(b);
      res.code = 8'(slot);
      res.alloc = fresh;
      return res;
    end
    if (relax_on) begin
      if (fwd_code[base + subst_byte] == 0) res.st = ST_DEFAULT_UND;
      else res.code = fwd_code[base + subst_byte];
      return res;
    end
    res.st = ST_UNHANDLED;
    return res;
  endfunction

  // Driver: present queued requests, hold until accepted
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) begin
        pending_reqs.pop_front();
        expected_results.push_back(translate({req_type, charset, byte_in, unicode_in,
                                              allow_alloc}));
        n_sent++;
      end
      if ((!in_valid || in_ready) && pending_reqs.size() > 0
          && !hold_send && $urandom_range(99) >= send_idle_pct) begin
        xlat_req_t nx;
        nx = pending_reqs[0];
        in_valid    <= 1'b1;
        req_type    <= nx.kind;
        charset     <= nx.cs;
        byte_in     <= nx.byt;
        unicode_in  <= nx.uni;
        allow_alloc <= nx.alloc;
      end else if (in_valid && in_ready) begin
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor: random back-pressure and result checking
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("[charset_translate_alloc_core] ERROR");
      $finish;
    end else begin
      if (!rst && out_valid && out_ready) begin
        n_recv++;
        if (expected_results.size() == 0) begin
          $error("result with nothing expected: code %0d status %0d", code_out, status);
          errors++;
        end else begin
          xlat_res_t ex;
          ex = expected_results.pop_front();
          if (status != ST_OK) n_err_status++;
          if (allocated) n_alloc++;
          if (code_out !== ex.code) begin
            $error("code_out expected %0d actual %0d", ex.code, code_out);
            errors++;
          end
          if (status !== ex.st) begin
            $error("status expected %0d actual %0d", ex.st, status);
            errors++;
          end
          if (allocated !== ex.alloc) begin
            $error("allocated expected %0d actual %0d", ex.alloc, allocated);
            errors++;
          end
        end
      end
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic add_req(logic [1:0] k, logic [2:0] c, logic [7:0] b, logic [15:0] u,
                         logic a);
    xlat_req_t r;
    r = '{kind: k, cs: c, byt: b, uni: u, alloc: a};
    pending_reqs.push_back(r);
  endtask

  // Mostly well-formed traffic: a random mix of loads, encodes and decodes over a small byte pool
  task automatic add_random(int n);
    logic [7:0] b;
    int pick;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(99);
      b = ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(24) + 120);
      if (pick < 25)
        add_req(REQ_LOAD, 3'($urandom_range(7)), b,
                ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(60) + 100),
                1'($urandom));
      else if (pick < 65)
        add_req(REQ_ENCODE, 3'($urandom_range(7)), b, 16'($urandom), 1'($urandom_range(3) != 0));
      else if (pick < 95)
        add_req(REQ_DECODE, 3'($urandom_range(7)), 8'($urandom), 16'($urandom), 1'($urandom));
      else
        add_req(2'd3, 3'($urandom), 8'($urandom), 16'($urandom), 1'($urandom));
    end
  endtask

  task automatic drain();
    wait (pending_reqs.size() == 0 && !in_valid);
    wait (expected_results.size() == 0);
    repeat (300) @(posedge clk);
  endtask

  task automatic write_cfg(logic idx, logic [7:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    if (idx == CFG_RELAX) relax_on = val[0];
    else subst_byte = val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    errors = 0; cycles = 0; n_sent = 0; n_recv = 0; n_alloc = 0; n_err_status = 0;
    hold_send = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    for (int i = 0; i < 256; i++) slot_uni[i] = '0;
    for (int i = 0; i < 2048; i++) begin
      byte_uni[i] = (i < 128) ? 16'(i) : '0;
      fwd_code[i] = (i < 128) ? 8'(i) : '0;
      rev_byte[i] = (i < 128) ? 8'(i) : '0;
    end
    relax_on = 0;
    subst_byte = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed: edges, each request kind, each status
    write_cfg(CFG_RELAX, 8'd0);
    write_cfg(CFG_DEFAULT, 8'd0);
    add_req(REQ_ENCODE, 3'd0, 8'd0, 16'd0, 1'b0);
    add_req(REQ_ENCODE, 3'd0, 8'd65, 16'd0, 1'b0);
    add_req(REQ_ENCODE, 3'd1, 8'd200, 16'd0, 1'b0);
    add_req(REQ_ENCODE, 3'd1, 8'd200, 16'd0, 1'b1);
    add_req(REQ_ENCODE, 3'd2, 8'd7, 16'd0, 1'b1);
    add_req(REQ_LOAD, 3'd1, 8'd200, 16'hFFFF, 1'b0);
    add_req(REQ_ENCODE, 3'd1, 8'd200, 16'h0, 1'b1);
    add_req(REQ_LOAD, 3'd7, 8'd255, 16'hFFFF, 1'b1);
    add_req(REQ_LOAD, 3'd3, 8'd10, 16'd0, 1'b0);
    add_req(REQ_DECODE, 3'd1, 8'd255, 16'd0, 1'b0);
    add_req(REQ_DECODE, 3'd7, 8'd255, 16'd0, 1'b0);
    add_req(REQ_DECODE, 3'd5, 8'd0, 16'd0, 1'b0);
    add_req(REQ_DECODE, 3'd5, 8'd99, 16'd0, 1'b0);
    add_req(2'd3, 3'd4, 8'd1, 16'd1, 1'b1);
    add_req(REQ_LOAD, 3'd0, 8'd130, 16'd65, 1'b0);
    drain();
    write_cfg(CFG_RELAX, 8'd1);
    write_cfg(CFG_DEFAULT, 8'd255);
    add_req(REQ_ENCODE, 3'd4, 8'd150, 16'd0, 1'b0);
    add_req(REQ_ENCODE, 3'd7, 8'd150, 16'd0, 1'b0);
    add_req(REQ_ENCODE, 3'd1, 8'd201, 16'd0, 1'b0);
    drain();
    write_cfg(CFG_DEFAULT, 8'd65);
    add_req(REQ_ENCODE, 3'd0, 8'd150, 16'd0, 1'b0);
    // Fill the code table to reach table-full
    for (int i = 0; i < 260; i++)
      add_req(REQ_LOAD, 3'd6, 8'(i), 16'(1000 + i), 1'b0);
    for (int i = 0; i < 260; i++)
      add_req(REQ_ENCODE, 3'd6, 8'(i), 16'd0, 1'b1);
    drain();

    // Random phases with varying flow control and config
    for (int ph = 0; ph < 6; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 72; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 72; end
        default: begin send_idle_pct = 29; recv_stall_pct = 29; end
      endcase
      write_cfg(CFG_RELAX, 8'(ph % 2));
      write_cfg(CFG_DEFAULT, (ph == 5) ? 8'd0 : 8'($urandom));
      add_random(100);
      // Pause the sender until all results are back
      hold_send = 1;
      wait (expected_results.size() == 0 && !in_valid);
      hold_send = 0;
      add_random(100);
      drain();
    end
    send_idle_pct = 0;
    recv_stall_pct = 0;
    drain();

    $display("Run covered %0d requests, %0d results, %0d fresh allocations, %0d error statuses.",
             n_sent, n_recv, n_alloc, n_err_status);
    if (errors == 0 && expected_results.size() == 0)
      $display("[charset_translate_alloc_core] OK");
    else
      $display("[charset_translate_alloc_core] ERROR");
    $finish;
  end

endmodule
